>>> src/rscl_pkg.sv
// Shared types and codes for the reference-counted slot cache lookup.
`default_nettype none

package rscl_pkg;

  // Request kinds.
  localparam logic KIND_LOCK   = 1'b0;
  localparam logic KIND_UNLOCK = 1'b1;

  // Reply status codes.
  localparam logic [2:0] STATUS_HIT    = 3'd0;
  localparam logic [2:0] STATUS_MISS   = 3'd1;
  localparam logic [2:0] STATUS_NULL   = 3'd2;
  localparam logic [2:0] STATUS_BUSY   = 3'd3;
  localparam logic [2:0] STATUS_UNLOCK = 3'd4;

  // Saturation limit of a reference count.
  localparam int         COUNT_BITS = 8;
  localparam logic [7:0] COUNT_MAX  = 8'd255;

  // Slots beyond this number have no transfer-idle bit.
  localparam int IDLE_BITS = 16;

  // Reset value of the slots-in-use register.
  localparam logic [4:0] SLOTS_IN_USE_RESET = 5'd16;

  // One request item.
  typedef struct packed {
    logic        kind;
    logic [31:0] address;
    logic [3:0]  release_slot;
    logic [15:0] transfer_idle;
  } request_t;

  // One reply item.
  typedef struct packed {
    logic [3:0] slot;
    logic [2:0] status;
  } reply_t;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_LOOKUP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_blocked;
  } stat_t;

endpackage

`default_nettype wire

>>> src/rscl_ctrl.sv
// Controller state machine for the slot cache lookup.
`default_nettype none

module rscl_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 request_valid,
  output logic                request_stall,
  input  rscl_pkg::stat_t     stat,
  output rscl_pkg::cmd_t      cmd
);

  rscl_pkg::state_t state;
  rscl_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rscl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next    = state;
    cmd           = '0;
    request_stall = 1'b1;
    case (state)
      rscl_pkg::S_IDLE: begin
        request_stall = 1'b0;
        if (request_valid) begin
          cmd.capture = 1'b1;
          state_next  = rscl_pkg::S_LOOKUP;
        end
      end
      rscl_pkg::S_LOOKUP: begin
        // Wait until the reply register can take the result.
        if (!stat.out_blocked) begin
          cmd.execute = 1'b1;
          state_next  = rscl_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rscl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/rscl_datapath.sv
// Datapath: slot addresses, reference counts, lookup and reply register.
`default_nettype none

module rscl_datapath #(
  parameter int SLOTS        = 16,
  parameter int ADDRESS_BITS = 32
) (
  input  wire                 clk,
  input  wire                 rst,
  input  rscl_pkg::request_t  request,
  input  wire                 config_write,
  input  wire  [4:0]          config_data,
  input  rscl_pkg::cmd_t      cmd,
  output rscl_pkg::stat_t     stat,
  output rscl_pkg::reply_t    reply,
  output logic                reply_valid,
  input  wire                 reply_stall
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  rscl_pkg::request_t               req_q;
  logic [4:0]                       slots_in_use;
  logic [ADDRESS_BITS-1:0]          slot_addr [SLOTS];
  logic [rscl_pkg::COUNT_BITS-1:0]  slot_count [SLOTS];

  logic [ADDRESS_BITS+31:0] key_ext;
  logic [ADDRESS_BITS-1:0]  key;
  logic                     is_null;
  logic [SLOTS-1:0]         active;
  logic [SLOTS-1:0]         hit;
  logic [SLOTS-1:0]         free;
  logic [SLOTS-1:0]         rel_sel;
  logic [SLOTS-1:0]         hit_first;
  logic [SLOTS-1:0]         free_first;
  logic [SLOTS-1:0]         chosen;
  logic                     any_hit;
  logic                     any_free;
  logic [IW-1:0]            chosen_idx;
  logic [IW+3:0]            idx_ext;
  rscl_pkg::reply_t         result;

  // Request capture and the configuration register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= request;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= rscl_pkg::SLOTS_IN_USE_RESET;
    end else if (config_write) begin
      slots_in_use <= config_data;
    end
  end

  // The lookup key is the address taken modulo the stored address width.
  assign key_ext = {{ADDRESS_BITS{1'b0}}, req_q.address};
  assign key     = key_ext[ADDRESS_BITS-1:0];
  assign is_null = (key == '0);

  // Per-slot match, free and release flags.
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      // A register value of zero still enables slot zero.
      active[s] = (s == 0) || (s < int'(slots_in_use));
      hit[s]    = active[s] && (slot_addr[s] == key);
      if (s < rscl_pkg::IDLE_BITS) begin
        free[s]    = active[s] && (slot_count[s] == '0) && req_q.transfer_idle[s];
        rel_sel[s] = active[s] && (int'(req_q.release_slot) == s);
      end else begin
        free[s]    = 1'b0;
        rel_sel[s] = 1'b0;
      end
    end
  end

  // Lowest matching and lowest free slot, one-hot.
  assign hit_first  = hit & (~hit + SLOTS'(1));
  assign free_first = free & (~free + SLOTS'(1));
  assign any_hit    = |hit;
  assign any_free   = |free;
  assign chosen     = any_hit ? hit_first : free_first;

  // Encode the chosen slot number.
  always_comb begin
    chosen_idx = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (chosen[s]) begin
        chosen_idx = chosen_idx | IW'(s);
      end
    end
  end

  assign idx_ext = {4'b0000, chosen_idx};

  // Reply for the current request.
  always_comb begin
    result = '0;
    if (req_q.kind == rscl_pkg::KIND_UNLOCK) begin
      result.slot   = req_q.release_slot;
      result.status = rscl_pkg::STATUS_UNLOCK;
    end else if (is_null) begin
      result.status = rscl_pkg::STATUS_NULL;
    end else if (any_hit) begin
      result.slot   = idx_ext[3:0];
      result.status = rscl_pkg::STATUS_HIT;
    end else if (any_free) begin
      result.slot   = idx_ext[3:0];
      result.status = rscl_pkg::STATUS_MISS;
    end else begin
      result.status = rscl_pkg::STATUS_BUSY;
    end
  end

  // Slot state update, each slot under its own enable.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SLOTS; s++) begin
        slot_addr[s]  <= '0;
        slot_count[s] <= '0;
      end
    end else if (cmd.execute) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (req_q.kind == rscl_pkg::KIND_UNLOCK) begin
          if (rel_sel[s] && (slot_count[s] != '0)) begin
            slot_count[s] <= slot_count[s] - rscl_pkg::COUNT_BITS'(1);
          end
        end else if (!is_null) begin
          if (any_hit) begin
            if (hit_first[s] && (slot_count[s] != rscl_pkg::COUNT_MAX)) begin
              slot_count[s] <= slot_count[s] + rscl_pkg::COUNT_BITS'(1);
            end
          end else if (free_first[s]) begin
            slot_addr[s]  <= key;
            slot_count[s] <= rscl_pkg::COUNT_BITS'(1);
          end
        end
      end
    end
  end

  // Reply register.
  always_ff @(posedge clk) begin
    if (rst) begin
      reply_valid <= 1'b0;
    end else if (cmd.execute) begin
      reply_valid <= 1'b1;
    end else if (!reply_stall) begin
      reply_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      reply <= result;
    end
  end

  assign stat.out_blocked = reply_valid && reply_stall;

endmodule

`default_nettype wire

>>> src/refcounted_slot_cache_lookup.sv
// Top level of the reference-counted slot cache lookup.
//
// Requests arrive on the request channel (request_valid, request_stall,
// request) and each gives exactly one item on the reply channel
// (reply_valid, reply_stall, reply). A lock request looks its address up in
// all active slots at once; a hit bumps the slot's count, a miss claims the
// lowest free slot, address zero answers null, and no free slot answers
// busy. An unlock request decrements the given slot's count.
// An accepted request is captured into a register; in the lookup state the
// parallel compare, priority pick and count update run and the reply is
// registered, and the block takes one request at a time. The reply sits in
// an output register. While the receiver stalls, the block still accepts
// one more request and holds it in the lookup state until the reply
// register frees. Synchronous reset clears all slot addresses and counts
// and sets slots_in_use to 16. config_write loads slots_in_use; the user
// must do so only while the block idles, which the block itself does not
// enforce.
`default_nettype none

module refcounted_slot_cache_lookup #(
  parameter int SLOTS        = 16,
  parameter int ADDRESS_BITS = 32
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 request_valid,
  output logic                request_stall,
  input  rscl_pkg::request_t  request,
  output logic                reply_valid,
  input  wire                 reply_stall,
  output rscl_pkg::reply_t    reply,
  input  wire                 config_write,
  input  wire  [4:0]          config_data
);

  rscl_pkg::cmd_t  cmd;
  rscl_pkg::stat_t stat;

  // Sequencing of capture and lookup.
  rscl_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .stat          (stat),
    .cmd           (cmd)
  );

  // Slot storage, lookup and reply register.
  rscl_datapath #(
    .SLOTS        (SLOTS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .request      (request),
    .config_write (config_write),
    .config_data  (config_data),
    .cmd          (cmd),
    .stat         (stat),
    .reply        (reply),
    .reply_valid  (reply_valid),
    .reply_stall  (reply_stall)
  );

endmodule

`default_nettype wire
